// ===== rtl/core/pbr_pkg.sv =====
// ----------------------------------------------------------------------------
// pbr_pkg
// shared types and constants of the playback ring with underrun restart
// ----------------------------------------------------------------------------
package pbr_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE   = 2'd0,
        FUNC_TICK    = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_RESTART = 2'd3
    } func_t;

    // one result beat as handed from the sequencer to the output register
    typedef struct packed {
        logic        status;
        logic [7:0]  read_data;
        logic [14:0] free_space;
        logic [14:0] queued;
        logic        underrun_seen;
        logic [15:0] underrun_count;
    } result_t;

    localparam logic [14:0] LEAD_RESET = 15'd512;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

endpackage

// ===== rtl/core/pbr_ring_mem.sv =====
// ----------------------------------------------------------------------------
// pbr_ring_mem
// sample byte store, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module pbr_ring_mem #(
    parameter int ADDR_W = 15
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/pbr_seq.sv =====
// ----------------------------------------------------------------------------
// pbr_seq
// sequencer: ring positions, gap and queue accounting, zeroing walk and sweep
// ----------------------------------------------------------------------------
module pbr_seq #(
    parameter int RING_BYTES = 32768,
    parameter int AW         = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          func,
    input  logic [7:0]          sample,
    input  logic [14:0]         position,
    input  logic [14:0]         restart_lead,
    output logic                res_valid,
    input  logic                res_ready,
    output pbr_pkg::result_t    res,
    output logic                mem_we,
    output logic [AW-1:0]       mem_waddr,
    output logic [7:0]          mem_wdata,
    output logic                mem_re,
    output logic [AW-1:0]       mem_raddr,
    input  logic [7:0]          mem_rdata
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_TICK,
        S_ZERO,
        S_FINISH
    } state_t;

    localparam logic [AW:0]   CAP   = (AW+1)'(RING_BYTES - 2);
    localparam logic [AW:0]   RMASK = (AW+1)'(RING_BYTES - 1);
    localparam logic [31:0]   LEAD_RST32 = {17'd0, pbr_pkg::LEAD_RESET};

    state_t             state_reg;
    logic               clr_result_reg;
    pbr_pkg::func_t     func_reg;
    logic [7:0]         sample_reg;
    logic [AW-1:0]      pos_reg;
    logic [AW-1:0]      write_pos_reg;
    logic [AW-1:0]      clean_pos_reg;
    logic [AW-1:0]      queued_reg;
    logic [AW-1:0]      gap_reg;
    logic [15:0]        count_reg;
    logic [AW-1:0]      walk_addr_reg;
    logic [AW-1:0]      walk_cnt_reg;
    logic               status_reg;
    logic               seen_reg;

    logic [AW:0]        used;
    logic [AW:0]        space;
    logic [AW-1:0]      n_calc;
    logic [AW:0]        n_ext;
    logic [AW-1:0]      lead_ring;
    logic [AW-1:0]      lead_sum;
    logic [AW-1:0]      wp_under;
    logic [AW-1:0]      gap_under;
    logic [31:0]        pos32;
    logic [31:0]        lead32;
    logic [31:0]        space32;
    logic [31:0]        used32;

    assign used      = {1'b0, gap_reg} + {1'b0, queued_reg};
    assign space     = (used >= CAP) ? '0 : CAP - used;
    assign n_calc    = pos_reg - clean_pos_reg;
    assign n_ext     = {1'b0, walk_cnt_reg};
    assign pos32     = {17'd0, position};
    assign lead32    = {17'd0, restart_lead};
    assign lead_ring = lead32[AW-1:0];
    assign lead_sum  = pos_reg + lead_ring;
    // restart point rounded down to even
    assign wp_under  = {lead_sum[AW-1:1], 1'b0};
    assign gap_under = wp_under - pos_reg;
    assign space32   = 32'(space);
    assign used32    = 32'(used);

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_FINISH);

    always_comb
    begin
        res.status         = status_reg;
        res.read_data      = (func_reg == pbr_pkg::FUNC_READ) ? mem_rdata : 8'd0;
        res.free_space     = space32[14:0];
        res.queued         = used32[14:0];
        res.underrun_seen  = seen_reg;
        res.underrun_count = count_reg;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = walk_addr_reg;
        mem_wdata = 8'd0;
        mem_re    = 1'b0;
        mem_raddr = pos_reg;
        unique case (state_reg)
            S_CLEAR, S_ZERO:
            begin
                mem_we = 1'b1;
            end
            S_EXEC:
            begin
                if (func_reg == pbr_pkg::FUNC_WRITE && space != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = write_pos_reg;
                    mem_wdata = sample_reg;
                end
                mem_re = (func_reg == pbr_pkg::FUNC_READ);
            end
            S_IDLE, S_TICK, S_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_result_reg <= 1'b0;
            write_pos_reg  <= LEAD_RST32[AW-1:0];
            gap_reg        <= LEAD_RST32[AW-1:0];
            clean_pos_reg  <= '0;
            queued_reg     <= '0;
            count_reg      <= '0;
            walk_addr_reg  <= '0;
            walk_cnt_reg   <= '0;
            status_reg     <= 1'b0;
            seen_reg       <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    walk_addr_reg <= walk_addr_reg + 1'b1;
                    if ({1'b0, walk_addr_reg} == RMASK)
                    begin
                        state_reg <= clr_result_reg ? S_FINISH : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    status_reg <= 1'b0;
                    seen_reg   <= 1'b0;
                    unique case (func_reg)
                        pbr_pkg::FUNC_WRITE:
                        begin
                            if (space == '0)
                            begin
                                status_reg <= 1'b1;
                            end
                            else
                            begin
                                write_pos_reg <= write_pos_reg + 1'b1;
                                queued_reg    <= queued_reg + 1'b1;
                            end
                            state_reg <= S_FINISH;
                        end
                        pbr_pkg::FUNC_TICK:
                        begin
                            walk_addr_reg <= clean_pos_reg;
                            walk_cnt_reg  <= n_calc;
                            state_reg     <= S_TICK;
                        end
                        pbr_pkg::FUNC_READ:
                        begin
                            state_reg <= S_FINISH;
                        end
                        pbr_pkg::FUNC_RESTART:
                        begin
                            clean_pos_reg  <= '0;
                            queued_reg     <= '0;
                            count_reg      <= '0;
                            gap_reg        <= lead_ring;
                            write_pos_reg  <= lead_ring;
                            walk_addr_reg  <= '0;
                            clr_result_reg <= 1'b1;
                            state_reg      <= S_CLEAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_TICK:
                begin
                    priority if (n_ext > used)
                    begin
                        if (queued_reg != '0)
                        begin
                            seen_reg <= 1'b1;
                            if (count_reg != pbr_pkg::COUNT_MAX)
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                        write_pos_reg <= wp_under;
                        gap_reg       <= gap_under;
                        queued_reg    <= '0;
                    end
                    else if (walk_cnt_reg > gap_reg)
                    begin
                        queued_reg <= queued_reg - (walk_cnt_reg - gap_reg);
                        gap_reg    <= '0;
                    end
                    else
                    begin
                        gap_reg <= gap_reg - walk_cnt_reg;
                    end
                    clean_pos_reg <= pos_reg;
                    state_reg     <= (walk_cnt_reg == '0) ? S_FINISH : S_ZERO;
                end
                S_ZERO:
                begin
                    // zero one played byte per cycle
                    walk_addr_reg <= walk_addr_reg + 1'b1;
                    walk_cnt_reg  <= walk_cnt_reg - 1'b1;
                    if (walk_cnt_reg == AW'(1))
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    clr_result_reg <= 1'b0;
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            func_reg   <= pbr_pkg::func_t'(func);
            sample_reg <= sample;
            pos_reg    <= pos32[AW-1:0];
        end
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_EXEC))
        else $error("accepted beat did not start execution");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("ring written while idle");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used <= RMASK)
        else $error("gap plus queued exceeds ring");

    a_queued_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (queued_reg != '0) |-> (used <= CAP))
        else $error("queued data overfills ring");

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TICK && count_reg == pbr_pkg::COUNT_MAX)
        |=> (count_reg == pbr_pkg::COUNT_MAX))
        else $error("underrun count wrapped");

endmodule

// ===== rtl/core/playback_ring_with_underrun_restart.sv =====
// ----------------------------------------------------------------------------
// playback_ring_with_underrun_restart
// byte ring for a playback engine with silence gap and underrun restart
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+------------------------------
//  in        | in        | in_valid / in_stall    | func, sample, position
//  out       | out       | out_valid / out_stall  | status, read_data, free_space,
//            |           |                        | queued, underrun_seen,
//            |           |                        | underrun_count
//  cfg       | in        | cfg_valid / cfg_ready  | cfg_data (restart_lead)
//
//  one beat at a time, taken only while idle; tick: zeroes n bytes, n =
//  bytes played since the last tick, one per cycle through the ring write port
//  restart: the whole ring is cleared, one ring entry cleared per cycle
//  after reset a clearing pass over the whole ring runs before the first beat
//  is taken; cfg writes are taken at any time
//  a result waits in the output register under out_stall; the next beat is
//  taken meanwhile and holds in its last cycle until the register frees up
// ----------------------------------------------------------------------------
module playback_ring_with_underrun_restart #(
    parameter int RING_BYTES = 32768
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  sample,
    input  logic [14:0] position,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [7:0]  read_data,
    output logic [14:0] free_space,
    output logic [14:0] queued,
    output logic        underrun_seen,
    output logic [15:0] underrun_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data
);

    localparam int AW = $clog2(RING_BYTES);

    logic [14:0]        restart_lead_reg;
    logic               out_valid_reg;
    pbr_pkg::result_t   out_res_reg;
    logic               res_valid;
    logic               res_ready;
    pbr_pkg::result_t   res;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [7:0]         mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [7:0]         mem_rdata;

    assign cfg_ready = 1'b1;
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_lead_reg <= pbr_pkg::LEAD_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                restart_lead_reg <= cfg_data;
            end
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_res_reg.status;
    assign read_data      = out_res_reg.read_data;
    assign free_space     = out_res_reg.free_space;
    assign queued         = out_res_reg.queued;
    assign underrun_seen  = out_res_reg.underrun_seen;
    assign underrun_count = out_res_reg.underrun_count;

    pbr_seq #(
        .RING_BYTES (RING_BYTES),
        .AW         (AW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .sample       (sample),
        .position     (position),
        .restart_lead (restart_lead_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    pbr_ring_mem #(
        .ADDR_W (AW)
    ) u_ring_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
